/* sv/skvt_pkg.sv */
// ----------------------------------------------------------------------------
// skvt_pkg - shared types and codes of the sorted key/value table
// Request and status codes, and the control word sent to every table cell.
// ----------------------------------------------------------------------------
package skvt_pkg;

	localparam int KEY_W   = 32;
	localparam int VALUE_W = 32;
	localparam int FUNC_W  = 2;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;

	localparam logic [FUNC_W-1:0] FUNC_PUT    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_GET    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

	typedef enum logic [1:0] {
		CELL_NOP  = 2'd0,
		CELL_INS  = 2'd1,
		CELL_DEL  = 2'd2,
		CELL_SETV = 2'd3
	} cell_op_t;

	typedef struct packed {
		logic     cmp;
		cell_op_t op;
	} cell_ctl_t;

endpackage

/* sv/skvt_req_if.sv */
// ----------------------------------------------------------------------------
// skvt_req_if - request channel
// valid/ready handshake carrying one put, get or remove word.
// ----------------------------------------------------------------------------
interface skvt_req_if;
	logic                            valid;
	logic                            ready;
	logic [skvt_pkg::FUNC_W-1:0]     func;
	logic signed [skvt_pkg::KEY_W-1:0]   key;
	logic signed [skvt_pkg::VALUE_W-1:0] value;

	modport source (output valid, output func, output key, output value, input ready);
	modport sink   (input valid, input func, input key, input value, output ready);
endinterface

/* sv/skvt_rsp_if.sv */
// ----------------------------------------------------------------------------
// skvt_rsp_if - response channel
// valid/ready handshake carrying the status, read value and entry count.
// ----------------------------------------------------------------------------
interface skvt_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [skvt_pkg::STAT_W-1:0]         status;
	logic signed [skvt_pkg::VALUE_W-1:0] read_value;
	logic [skvt_pkg::COUNT_W-1:0]        entry_count;

	modport source (output valid, output status, output read_value, output entry_count,
		input ready);
	modport sink   (input valid, input status, input read_value, input entry_count,
		output ready);
endinterface

/* sv/skvt_cell.sv */
// ----------------------------------------------------------------------------
// skvt_cell - one slot of the sorted table
// Holds one pair, compares its key against the request and shifts with its
// neighbors on insert or remove.
// ----------------------------------------------------------------------------
module skvt_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  skvt_pkg::cell_ctl_t                 ctl,
	input  logic                                occ,
	input  logic signed [skvt_pkg::KEY_W-1:0]   cmp_key,
	input  logic signed [skvt_pkg::KEY_W-1:0]   req_key,
	input  logic signed [skvt_pkg::VALUE_W-1:0] req_value,
	input  logic                                left_less,
	input  logic signed [skvt_pkg::KEY_W-1:0]   left_key,
	input  logic signed [skvt_pkg::VALUE_W-1:0] left_value,
	input  logic signed [skvt_pkg::KEY_W-1:0]   right_key,
	input  logic signed [skvt_pkg::VALUE_W-1:0] right_value,
	output logic signed [skvt_pkg::KEY_W-1:0]   key,
	output logic signed [skvt_pkg::VALUE_W-1:0] value,
	output logic                                less,
	output logic                                eq
);

	logic signed [skvt_pkg::KEY_W-1:0]   key_q;
	logic signed [skvt_pkg::VALUE_W-1:0] value_q;
	logic                                less_q;
	logic                                eq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			less_q <= 1'b0;
			eq_q   <= 1'b0;
		end else if (ctl.cmp) begin
			less_q <= occ && (key_q < cmp_key);
			eq_q   <= occ && (key_q == cmp_key);
		end
	end

	// cells at and above the lower bound move; those below hold
	always_ff @(posedge clk) begin
		case (ctl.op)
			skvt_pkg::CELL_INS: begin
				if (!less_q) begin
					if (left_less) begin
						key_q   <= req_key;
						value_q <= req_value;
					end else begin
						key_q   <= left_key;
						value_q <= left_value;
					end
				end
			end
			skvt_pkg::CELL_DEL: begin
				if (!less_q) begin
					key_q   <= right_key;
					value_q <= right_value;
				end
			end
			skvt_pkg::CELL_SETV: begin
				if (eq_q)
					value_q <= req_value;
			end
			default: ;
		endcase
	end

	assign key   = key_q;
	assign value = value_q;
	assign less  = less_q;
	assign eq    = eq_q;

endmodule

/* sv/sorted_key_value_table_top.sv */
// ----------------------------------------------------------------------------
// sorted_key_value_table_top - sorted key/value table
// Row of cells keeping up to CAPACITY pairs in ascending signed key order.
//
//   port  dir   word
//   req   sink  func, key, value
//   rsp   src   status, read_value, entry_count
//
// All cells compare their key with the request in the accept cycle, then the
// row shifts or writes in the update cycle.
// The update waits while the result register is still held by rsp.
// One request is in flight at a time; req.ready is high only when idle.
// Reset clears the entry count; cell contents need no clearing.
// ----------------------------------------------------------------------------
module sorted_key_value_table_top #(
	parameter int CAPACITY = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	skvt_req_if.sink   req,
	skvt_rsp_if.source rsp
);

	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_UPD  = 2'b10
	} state_t;

	state_t                                state_q;
	logic [CW-1:0]                         cnt_q;
	logic [skvt_pkg::FUNC_W-1:0]           func_q;
	logic signed [skvt_pkg::KEY_W-1:0]     key_q;
	logic signed [skvt_pkg::VALUE_W-1:0]   value_q;

	logic                                  out_valid_q;
	logic [skvt_pkg::STAT_W-1:0]           out_status_q;
	logic signed [skvt_pkg::VALUE_W-1:0]   out_value_q;
	logic [skvt_pkg::COUNT_W-1:0]          out_count_q;

	logic signed [skvt_pkg::KEY_W-1:0]     cell_key   [CAPACITY];
	logic signed [skvt_pkg::VALUE_W-1:0]   cell_value [CAPACITY];
	logic [CAPACITY-1:0]                   less_all;
	logic [CAPACITY-1:0]                   eq_all;
	logic [CAPACITY-1:0]                   occ;

	logic                                  accept;
	logic                                  commit;
	logic                                  hit;
	logic signed [skvt_pkg::VALUE_W-1:0]   hit_value;
	skvt_pkg::cell_ctl_t                   ctl;
	skvt_pkg::cell_op_t                    upd_op;
	logic [skvt_pkg::STAT_W-1:0]           nxt_status;
	logic signed [skvt_pkg::VALUE_W-1:0]   nxt_value;
	logic [CW-1:0]                         nxt_cnt;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign commit    = (state_q == S_UPD) && (!out_valid_q || rsp.ready);

	assign hit = |eq_all;

	always_comb begin
		hit_value = '0;
		for (int i = 0; i < CAPACITY; i++)
			hit_value = hit_value | (cell_value[i] & {skvt_pkg::VALUE_W{eq_all[i]}});
	end

	always_comb begin
		upd_op     = skvt_pkg::CELL_NOP;
		nxt_status = skvt_pkg::STAT_OK;
		nxt_value  = '0;
		nxt_cnt    = cnt_q;
		case (func_q)
			skvt_pkg::FUNC_PUT: begin
				if (hit) begin
					upd_op = skvt_pkg::CELL_SETV;
				end else if (cnt_q == CW'(CAPACITY)) begin
					nxt_status = skvt_pkg::STAT_FULL;
				end else begin
					upd_op  = skvt_pkg::CELL_INS;
					nxt_cnt = cnt_q + 1'b1;
				end
			end
			skvt_pkg::FUNC_GET: begin
				if (hit)
					nxt_value = hit_value;
				else
					nxt_status = skvt_pkg::STAT_NOT_FOUND;
			end
			skvt_pkg::FUNC_REMOVE: begin
				if (hit) begin
					upd_op  = skvt_pkg::CELL_DEL;
					nxt_cnt = cnt_q - 1'b1;
				end else begin
					nxt_status = skvt_pkg::STAT_NOT_FOUND;
				end
			end
			default: ;
		endcase
	end

	assign ctl.cmp = accept;
	assign ctl.op  = commit ? upd_op : skvt_pkg::CELL_NOP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit)
				out_valid_q <= 1'b1;
			else if (rsp.valid && rsp.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= S_UPD;
				end
				S_UPD: begin
					if (commit) begin
						state_q <= S_IDLE;
						cnt_q   <= nxt_cnt;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= req.func;
			key_q   <= req.key;
			value_q <= req.value;
		end
		if (commit) begin
			out_status_q <= nxt_status;
			out_value_q  <= nxt_value;
			out_count_q  <= skvt_pkg::COUNT_W'(nxt_cnt);
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                                left_less;
		logic signed [skvt_pkg::KEY_W-1:0]   left_key;
		logic signed [skvt_pkg::VALUE_W-1:0] left_value;
		logic signed [skvt_pkg::KEY_W-1:0]   right_key;
		logic signed [skvt_pkg::VALUE_W-1:0] right_value;

		assign occ[i] = (cnt_q > CW'(i));

		if (i == 0) begin : g_first
			assign left_less  = 1'b1;
			assign left_key   = key_q;
			assign left_value = value_q;
		end else begin : g_mid
			assign left_less  = less_all[i-1];
			assign left_key   = cell_key[i-1];
			assign left_value = cell_value[i-1];
		end

		// the top cell has no right neighbor; what it takes on remove is unused
		if (i == CAPACITY - 1) begin : g_last
			assign right_key   = cell_key[i];
			assign right_value = cell_value[i];
		end else begin : g_inner
			assign right_key   = cell_key[i+1];
			assign right_value = cell_value[i+1];
		end

		skvt_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.occ         (occ[i]),
			.cmp_key     (req.key),
			.req_key     (key_q),
			.req_value   (value_q),
			.left_less   (left_less),
			.left_key    (left_key),
			.left_value  (left_value),
			.right_key   (right_key),
			.right_value (right_value),
			.key         (cell_key[i]),
			.value       (cell_value[i]),
			.less        (less_all[i]),
			.eq          (eq_all[i])
		);
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.read_value  = out_value_q;
	assign rsp.entry_count = out_count_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_eq_single: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UPD |-> $onehot0(eq_all))
		else $error("key matched in more than one cell");

	// keys are sorted, so the below-key flags form a run from cell 0
	a_less_thermo: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UPD |-> ((less_all + 1'b1) & less_all) == '0)
		else $error("cell order broken");

	a_less_occ: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UPD |-> ((less_all | eq_all) & ~occ) == '0)
		else $error("empty cell flagged in compare");

	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid_q && state_q == S_IDLE)
		else $error("result not registered after update");

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb - self-checking bench for the sorted key/value table
// Drives put/get/remove/unused words through the request channel with random
// gaps and stalls, tracks the table contents in a behavioral shadow, and
// compares every response word field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;

	localparam int TABLE_DEPTH  = 16;
	localparam int RANDOM_WORDS = 800;
	localparam int POOL_SIZE    = 24;
	localparam int MAX_GAP      = 13;
	localparam int LONG_HOLD    = 80;

	localparam logic [skvt_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam logic signed [skvt_pkg::KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [skvt_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [skvt_pkg::STAT_W-1:0]         status;
		logic signed [skvt_pkg::VALUE_W-1:0] read_value;
		logic [skvt_pkg::COUNT_W-1:0]        entry_count;
	} table_result_t;

	typedef struct {
		logic [skvt_pkg::FUNC_W-1:0]         func;
		logic signed [skvt_pkg::KEY_W-1:0]   key;
		logic signed [skvt_pkg::VALUE_W-1:0] value;
		bit                                  typed;
		table_result_t                       want;
	} script_row_t;

	logic clk;
	logic arst_n;

	skvt_req_if req ();
	skvt_rsp_if rsp ();

	sorted_key_value_table_top #(.CAPACITY(TABLE_DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// shadow of the table contents
	logic signed [skvt_pkg::KEY_W-1:0]   shadow_keys [TABLE_DEPTH];
	logic signed [skvt_pkg::VALUE_W-1:0] shadow_values [TABLE_DEPTH];
	int                                  shadow_count;

	table_result_t expected_results [$];
	script_row_t   directed_rows [$];
	logic signed [skvt_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
	int failures;
	int results_seen;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic table_result_t apply_request(input logic [skvt_pkg::FUNC_W-1:0] f,
			input logic signed [skvt_pkg::KEY_W-1:0] k,
			input logic signed [skvt_pkg::VALUE_W-1:0] v);
		table_result_t r;
		int pos;
		int j;
		bit hit;
		r.status = skvt_pkg::STAT_OK;
		r.read_value = '0;
		pos = 0;
		while (pos < shadow_count && shadow_keys[pos] < k)
			pos++;
		hit = (pos < shadow_count) && (shadow_keys[pos] == k);
		case (f)
			skvt_pkg::FUNC_PUT: begin
				if (hit) begin
					shadow_values[pos] = v;
				end else if (shadow_count >= TABLE_DEPTH) begin
					r.status = skvt_pkg::STAT_FULL;
				end else begin
					for (j = shadow_count; j > pos; j--) begin
						shadow_keys[j] = shadow_keys[j-1];
						shadow_values[j] = shadow_values[j-1];
					end
					shadow_keys[pos] = k;
					shadow_values[pos] = v;
					shadow_count++;
				end
			end
			skvt_pkg::FUNC_GET: begin
				if (hit)
					r.read_value = shadow_values[pos];
				else
					r.status = skvt_pkg::STAT_NOT_FOUND;
			end
			skvt_pkg::FUNC_REMOVE: begin
				if (hit) begin
					for (j = pos; j + 1 < shadow_count; j++) begin
						shadow_keys[j] = shadow_keys[j+1];
						shadow_values[j] = shadow_values[j+1];
					end
					shadow_count--;
				end else begin
					r.status = skvt_pkg::STAT_NOT_FOUND;
				end
			end
			default: ;
		endcase
		r.entry_count = skvt_pkg::COUNT_W'(shadow_count);
		return r;
	endfunction

	function automatic script_row_t row(input logic [skvt_pkg::FUNC_W-1:0] f,
			input logic signed [skvt_pkg::KEY_W-1:0] k,
			input logic signed [skvt_pkg::VALUE_W-1:0] v,
			input bit typed, input logic [skvt_pkg::STAT_W-1:0] st,
			input logic signed [skvt_pkg::VALUE_W-1:0] rv,
			input logic [skvt_pkg::COUNT_W-1:0] cnt);
		script_row_t r;
		r.func = f;
		r.key = k;
		r.value = v;
		r.typed = typed;
		r.want.status = st;
		r.want.read_value = rv;
		r.want.entry_count = cnt;
		return r;
	endfunction

	// Offer one word after an idle gap; returns the shadow's prediction once accepted.
	task automatic send_word(input logic [skvt_pkg::FUNC_W-1:0] f,
			input logic signed [skvt_pkg::KEY_W-1:0] k,
			input logic signed [skvt_pkg::VALUE_W-1:0] v, input int gap,
			output table_result_t predicted);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.func  <= f;
		req.key   <= k;
		req.value <= v;
		do @(posedge clk); while (!req.ready);
		predicted = apply_request(f, k, v);
	endtask

	// request side
	initial begin
		table_result_t predicted;
		script_row_t   r;
		logic [skvt_pkg::FUNC_W-1:0]         f;
		logic signed [skvt_pkg::KEY_W-1:0]   k;
		logic signed [skvt_pkg::VALUE_W-1:0] v;
		int put_weight;
		bit quiet;
		int gap;
		int pick;

		failures = 0;
		shadow_count = 0;
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.func  <= skvt_pkg::FUNC_PUT;
		req.key   <= '0;
		req.value <= '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			shadow_keys[i] = '0;
			shadow_values[i] = '0;
		end

		directed_rows.push_back(row(skvt_pkg::FUNC_GET, 0, 0, 1,
			skvt_pkg::STAT_NOT_FOUND, 0, 0));
		directed_rows.push_back(row(skvt_pkg::FUNC_REMOVE, 5, 0, 1,
			skvt_pkg::STAT_NOT_FOUND, 0, 0));
		directed_rows.push_back(row(skvt_pkg::FUNC_PUT, KEY_MAX, KEY_MIN, 1,
			skvt_pkg::STAT_OK, 0, 1));
		directed_rows.push_back(row(skvt_pkg::FUNC_PUT, KEY_MIN, KEY_MAX, 1,
			skvt_pkg::STAT_OK, 0, 2));
		directed_rows.push_back(row(skvt_pkg::FUNC_GET, KEY_MAX, 0, 1,
			skvt_pkg::STAT_OK, KEY_MIN, 2));
		directed_rows.push_back(row(skvt_pkg::FUNC_PUT, 0, 0, 1, skvt_pkg::STAT_OK, 0, 3));
		// a zero value must not block the remove
		directed_rows.push_back(row(skvt_pkg::FUNC_REMOVE, 0, -1, 1,
			skvt_pkg::STAT_OK, 0, 2));
		directed_rows.push_back(row(FUNC_UNUSED, KEY_MAX, -1, 1, skvt_pkg::STAT_OK, 0, 2));
		directed_rows.push_back(row(skvt_pkg::FUNC_PUT, KEY_MIN, -1, 1,
			skvt_pkg::STAT_OK, 0, 2));
		directed_rows.push_back(row(skvt_pkg::FUNC_GET, KEY_MIN, 7, 1,
			skvt_pkg::STAT_OK, -1, 2));
		// fill up in scrambled key order
		directed_rows.push_back(row(skvt_pkg::FUNC_PUT, 100, 11, 0, skvt_pkg::STAT_OK, 0, 0));
		directed_rows.push_back(row(skvt_pkg::FUNC_PUT, -100, 12, 0, skvt_pkg::STAT_OK, 0, 0));
		directed_rows.push_back(row(skvt_pkg::FUNC_PUT, 50, 13, 0, skvt_pkg::STAT_OK, 0, 0));
		directed_rows.push_back(row(skvt_pkg::FUNC_PUT, 7, 14, 0, skvt_pkg::STAT_OK, 0, 0));
		directed_rows.push_back(row(skvt_pkg::FUNC_PUT, -7, 15, 0, skvt_pkg::STAT_OK, 0, 0));
		directed_rows.push_back(row(skvt_pkg::FUNC_PUT, 3, 16, 0, skvt_pkg::STAT_OK, 0, 0));
		directed_rows.push_back(row(skvt_pkg::FUNC_PUT, 1000, 17, 0, skvt_pkg::STAT_OK, 0, 0));
		directed_rows.push_back(row(skvt_pkg::FUNC_PUT, -1, 18, 0, skvt_pkg::STAT_OK, 0, 0));
		directed_rows.push_back(row(skvt_pkg::FUNC_PUT, 1, 19, 0, skvt_pkg::STAT_OK, 0, 0));
		directed_rows.push_back(row(skvt_pkg::FUNC_PUT, 2, 20, 0, skvt_pkg::STAT_OK, 0, 0));
		directed_rows.push_back(row(skvt_pkg::FUNC_PUT, 32'sh4000_0000, 21, 0,
			skvt_pkg::STAT_OK, 0, 0));
		directed_rows.push_back(row(skvt_pkg::FUNC_PUT, 32'shC000_0000, 22, 0,
			skvt_pkg::STAT_OK, 0, 0));
		directed_rows.push_back(row(skvt_pkg::FUNC_PUT, 9, 23, 0, skvt_pkg::STAT_OK, 0, 0));
		directed_rows.push_back(row(skvt_pkg::FUNC_PUT, -9, 24, 0, skvt_pkg::STAT_OK, 0, 0));
		directed_rows.push_back(row(skvt_pkg::FUNC_PUT, 42, 99, 1,
			skvt_pkg::STAT_FULL, 0, 16));
		directed_rows.push_back(row(skvt_pkg::FUNC_PUT, 7, -5, 1, skvt_pkg::STAT_OK, 0, 16));
		directed_rows.push_back(row(skvt_pkg::FUNC_GET, 42, 0, 1,
			skvt_pkg::STAT_NOT_FOUND, 0, 16));

		key_pool[0] = KEY_MIN;
		key_pool[1] = KEY_MAX;
		key_pool[2] = 0;
		key_pool[3] = -1;
		key_pool[4] = 1;
		for (int i = 5; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			r = directed_rows[i];
			send_word(r.func, r.key, r.value, $urandom_range(0, MAX_GAP), predicted);
			expected_results.push_back(r.typed ? r.want : predicted);
		end

		put_weight = 50;
		quiet = 1'b0;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 50 == 0) begin
				put_weight = $urandom_range(20, 80);
				quiet = ($urandom_range(0, 3) == 0);
			end
			if (n % 200 == 100) begin
				for (int i = 5; i < POOL_SIZE; i++)
					key_pool[i] = $urandom;
			end
			if (n == RANDOM_WORDS / 2) begin
				// let every outstanding response arrive before going on
				req.valid <= 1'b0;
				while (expected_results.size() != 0) @(posedge clk);
			end
			pick = $urandom_range(0, 99);
			if (pick < 3)
				f = FUNC_UNUSED;
			else if ($urandom_range(0, 99) < put_weight)
				f = skvt_pkg::FUNC_PUT;
			else if ($urandom_range(0, 1) == 0)
				f = skvt_pkg::FUNC_GET;
			else
				f = skvt_pkg::FUNC_REMOVE;
			if ($urandom_range(0, 9) < 7)
				k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				k = $urandom;
			v = ($urandom_range(0, 7) == 0) ? '0 : $urandom;
			gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
			send_word(f, k, v, gap, predicted);
			expected_results.push_back(predicted);
		end
		req.valid <= 1'b0;

		while (expected_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// response side
	initial begin
		table_result_t got;
		table_result_t want;
		int stall;
		bit quiet;

		results_seen = 0;
		quiet = 1'b0;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (results_seen % 50 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			if (results_seen == 200)
				stall = LONG_HOLD;  // long hold-off: block must back up into req
			else
				stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
			got.status = rsp.status;
			got.read_value = rsp.read_value;
			got.entry_count = rsp.entry_count;
			results_seen++;
			if (expected_results.size() == 0) begin
				$error("unexpected response word: status %0d read_value %0d entry_count %0d",
					got.status, got.read_value, got.entry_count);
				failures++;
			end else begin
				want = expected_results.pop_front();
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					failures++;
				end
				if (got.read_value !== want.read_value) begin
					$error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
					failures++;
				end
				if (got.entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, got %0d", want.entry_count,
						got.entry_count);
					failures++;
				end
			end
		end
	end

endmodule
